>>> design/rmm_pkg.sv
// rmm_pkg: shared widths, limits and operation codes for the region mean merge block
// no dependencies; compiled first
package rmm_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CFG_W  = 5;
    localparam int OP_W   = 2;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 24;
    localparam int DIST_W = 20;
    localparam int N_W    = CNT_W + 1;
    localparam int PROD_W = VAL_W + CNT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int DIV_CW = $clog2(VAL_W);

    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(3);
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_MERGE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

endpackage

>>> design/rmm_if.sv
// rmm_if: valid/ready channel interfaces for input elements and results
// depends on rmm_pkg
interface rmm_in_if
    import rmm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [VAL_W-1:0] feature_value;
    logic [CNT_W-1:0] region_pixel_count;

    modport source (output valid, output operation, output feature_value,
                    output region_pixel_count, input ready);
    modport sink   (input valid, input operation, input feature_value,
                    input region_pixel_count, output ready);
endinterface

interface rmm_out_if
    import rmm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   completed_operation;
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  total_pixel_count;

    modport source (output valid, output completed_operation, output distance,
                    output total_pixel_count, input ready);
    modport sink   (input valid, input completed_operation, input distance,
                    input total_pixel_count, output ready);
endinterface

>>> design/region_mean_merge_l1_distance.sv
// region_mean_merge_l1_distance: stored region vector with load, l1 query and weighted merge
// depends on rmm_pkg and rmm_if; one shared multiplier and a bit-serial restoring divider
// sequence: load and query beats pass exec then done; merge beats add mul and div unless both counts are zero
// merge: two multiply steps on the shared multiplier, then one quotient bit per cycle
// throughput: one beat at a time, ready only while idle; a last beat stalls while a result waits
// reset: async active low; count, position, accumulator cleared, channel_count 3, means undefined
module region_mean_merge_l1_distance
    import rmm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CFG_W-1:0] cfg_write_data,
    rmm_in_if.sink           in_ch,
    rmm_out_if.source        out_ch
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   chan_count_reg, chan_count_next;
    logic [CH_W-1:0]    chan_pos_reg, chan_pos_next;
    logic [DIST_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;

    op_t                op_reg, op_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]   d_reg, d_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic [CH_W-1:0]    item_pos_reg, item_pos_next;
    logic               last_reg, last_next;
    logic [SUM_W-1:0]   prod_reg, prod_next;
    logic [N_W-1:0]     rem_reg, rem_next;
    logic [VAL_W-1:0]   quo_reg, quo_next;
    logic [DIV_CW-1:0]  div_cnt_reg, div_cnt_next;
    logic [OP_W-1:0]    out_op_reg, out_op_next;
    logic [DIST_W-1:0]  out_dist_reg, out_dist_next;
    logic [CNT_W-1:0]   out_total_reg, out_total_next;

    logic [VAL_W-1:0]   means [MAX_CHANNELS];
    logic [VAL_W-1:0]   mean_reg;
    logic               mem_we;
    logic [VAL_W-1:0]   mem_wdata;

    logic               in_fire;
    logic [CH_W:0]      eff_count;
    logic               is_last;
    logic [VAL_W-1:0]   mul_a;
    logic [CNT_W-1:0]   mul_b;
    logic [PROD_W-1:0]  product;
    logic [SUM_W-1:0]   sum;
    logic [N_W:0]       trial;
    logic [DIST_W-1:0]  acc_base;
    logic [VAL_W-1:0]   diff;
    logic [DIST_W:0]    acc_sum;

    assign in_ch.ready               = (state_reg == S_IDLE);
    assign in_fire                   = in_ch.valid && in_ch.ready;
    assign out_ch.valid              = out_valid_reg;
    assign out_ch.completed_operation = out_op_reg;
    assign out_ch.distance           = out_dist_reg;
    assign out_ch.total_pixel_count  = out_total_reg;

    always_comb
    begin
        if (chan_count_reg == '0)
        begin
            eff_count = (CH_W+1)'(1);
        end
        else if (32'(chan_count_reg) > MAX_CHANNELS)
        begin
            eff_count = (CH_W+1)'(MAX_CHANNELS);
        end
        else
        begin
            eff_count = (CH_W+1)'(chan_count_reg);
        end
    end

    assign is_last = (({1'b0, chan_pos_reg} + 1'b1) >= eff_count);

    // shared multiplier: stored mean times stored count, then value times incoming count
    assign mul_a   = (state_reg == S_MUL) ? val_reg : mean_reg;
    assign mul_b   = (state_reg == S_MUL) ? d_reg : count_reg;
    assign product = mul_a * mul_b;
    assign sum     = prod_reg + SUM_W'(product);
    assign trial   = {rem_reg, quo_reg[VAL_W-1]};
    assign diff    = (mean_reg >= val_reg) ? (mean_reg - val_reg) : (val_reg - mean_reg);
    assign acc_base = (item_pos_reg == '0) ? '0 : acc_reg;
    assign acc_sum  = {1'b0, acc_base} + (DIST_W+1)'(diff);

    always_comb
    begin
        state_next      = state_reg;
        chan_count_next = cfg_write_en ? cfg_write_data : chan_count_reg;
        chan_pos_next   = chan_pos_reg;
        acc_next        = acc_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        d_next          = d_reg;
        n_next          = n_reg;
        item_pos_next   = item_pos_reg;
        last_next       = last_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        out_op_next     = out_op_reg;
        out_dist_next   = out_dist_reg;
        out_total_next  = out_total_reg;
        mem_we          = 1'b0;
        mem_wdata       = val_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (op_t'(in_ch.operation) != OP_NONE))
                begin
                    op_next       = op_t'(in_ch.operation);
                    val_next      = in_ch.feature_value;
                    d_next        = in_ch.region_pixel_count;
                    n_next        = {1'b0, count_reg} + {1'b0, in_ch.region_pixel_count};
                    item_pos_next = chan_pos_reg;
                    last_next     = is_last;
                    chan_pos_next = is_last ? '0 : chan_pos_reg + 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                acc_next = acc_base;
                case (op_reg)
                    OP_LOAD:
                    begin
                        mem_we     = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_QUERY:
                    begin
                        acc_next   = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];
                        state_next = S_DONE;
                    end
                    OP_MERGE:
                    begin
                        if (n_reg == '0)
                        begin
                            quo_next   = mean_reg;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            // rounding term n/2 folded into the first partial sum
                            prod_next  = SUM_W'(product) + SUM_W'(n_reg[N_W-1:1]);
                            state_next = S_MUL;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MUL:
            begin
                // quotient fits 16 bits, so the upper bits start below n
                rem_next     = sum[SUM_W-1:VAL_W];
                quo_next     = sum[VAL_W-1:0];
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (trial >= {1'b0, n_reg})
                begin
                    rem_next = N_W'(trial - {1'b0, n_reg});
                    quo_next = {quo_reg[VAL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[N_W-1:0];
                    quo_next = {quo_reg[VAL_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CW'(VAL_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (op_reg == OP_MERGE)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = quo_reg;
                end
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || out_ch.ready)
                begin
                    case (op_reg)
                        OP_LOAD:
                        begin
                            count_next     = d_reg;
                            out_total_next = d_reg;
                            out_dist_next  = '0;
                        end
                        OP_MERGE:
                        begin
                            count_next     = n_reg[CNT_W] ? CNT_MAX : n_reg[CNT_W-1:0];
                            out_total_next = n_reg[CNT_W] ? CNT_MAX : n_reg[CNT_W-1:0];
                            out_dist_next  = '0;
                        end
                        default:
                        begin
                            out_total_next = count_reg;
                            out_dist_next  = acc_reg;
                        end
                    endcase
                    out_op_next    = op_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            chan_count_reg <= CFG_RESET;
            chan_pos_reg   <= '0;
            acc_reg        <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chan_count_reg <= chan_count_next;
            chan_pos_reg   <= chan_pos_next;
            acc_reg        <= acc_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        d_reg         <= d_next;
        n_reg         <= n_next;
        item_pos_reg  <= item_pos_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_cnt_reg   <= div_cnt_next;
        out_op_reg    <= out_op_next;
        out_dist_reg  <= out_dist_next;
        out_total_reg <= out_total_next;
    end

    // channel mean storage, registered read at accept
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            means[item_pos_reg] <= mem_wdata;
        end
        if (in_fire)
        begin
            mean_reg <= means[chan_pos_reg];
        end
    end

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < n_reg))
        else $error("divider remainder not below divisor");

    a_acc_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && item_pos_reg == '0 && op_reg != OP_QUERY) |=> (acc_reg == '0))
        else $error("accumulator not cleared on first beat of vector");

    a_no_result_mid_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !last_reg) |=> !(out_valid_reg && !$past(out_valid_reg)))
        else $error("result produced on a beat that does not end the vector");

    a_ignored_op_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op_t'(in_ch.operation) == OP_NONE)
        |=> ($stable(chan_pos_reg) && state_reg == S_IDLE))
        else $error("ignored operation changed sequencing state");
`endif

endmodule

>>> tb/tb_region_mean_merge_l1_distance.sv
`timescale 1ns / 1ps
// tb_region_mean_merge_l1_distance: self-checking bench for the region mean merge block
// a scoreboard class predicts load, query and merge results; tasks drive the element channel
// depends on rmm_pkg, rmm_if and region_mean_merge_l1_distance
module tb_region_mean_merge_l1_distance;
    import rmm_pkg::*;

    localparam int RUN_LIMIT    = 300000;
    localparam int DRAIN_CYCLES = 25;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 40;

    typedef struct packed {
        op_t               op;
        logic [DIST_W-1:0] l1_dist;
        logic [CNT_W-1:0]  total;
    } region_result_t;

    class region_tracker;
        logic [VAL_W-1:0]  means [MAX_CHANNELS];
        bit                written [MAX_CHANNELS];
        logic [CNT_W-1:0]  region_total;
        int unsigned       position;
        logic [DIST_W-1:0] dist_sum;
        logic [CFG_W-1:0]  channels;
        region_result_t    pending [$];
        int                mismatches;

        function new();
            region_total = '0;
            position     = 0;
            dist_sum     = '0;
            channels     = CFG_RESET;
            mismatches   = 0;
            foreach (written[i])
                written[i] = 1'b0;
        endfunction

        function int unsigned active_channels();
            if (channels == 0)
                return 1;
            if (channels > MAX_CHANNELS)
                return MAX_CHANNELS;
            return channels;
        endfunction

        function void set_channels(logic [CFG_W-1:0] value);
            channels = value;
        endfunction

        function void note_element(op_t op, logic [VAL_W-1:0] v, logic [CNT_W-1:0] d);
            logic [63:0]       sum;
            logic [63:0]       n;
            logic [VAL_W-1:0]  m;
            logic [VAL_W:0]    diff;
            logic [DIST_W:0]   acc;
            logic [CNT_W:0]    total;
            int unsigned       pos;
            region_result_t    res;
            if (op == OP_NONE)
                return;
            pos = position;
            if (pos >= MAX_CHANNELS)
                pos = MAX_CHANNELS - 1;
            if (pos == 0)
                dist_sum = '0;
            case (op)
                OP_LOAD:
                begin
                    means[pos]   = v;
                    written[pos] = 1'b1;
                end
                OP_QUERY:
                begin
                    m    = means[pos];
                    diff = (m >= v) ? m - v : v - m;
                    acc  = dist_sum + diff;
                    dist_sum = (acc > DIST_MAX) ? DIST_MAX : acc[DIST_W-1:0];
                end
                OP_MERGE:
                begin
                    n = 64'(region_total) + 64'(d);
                    if (n != 0)
                    begin
                        sum = 64'(means[pos]) * 64'(region_total) + 64'(v) * 64'(d);
                        means[pos] = VAL_W'((sum + n / 2) / n);
                    end
                end
                default: ;
            endcase
            if (pos + 1 < active_channels())
            begin
                position = pos + 1;
                return;
            end
            position = 0;
            if (op == OP_LOAD)
                region_total = d;
            else if (op == OP_MERGE)
            begin
                total = region_total + d;
                region_total = (total > CNT_MAX) ? CNT_MAX : total[CNT_W-1:0];
            end
            res.op      = op;
            res.l1_dist = (op == OP_QUERY) ? dist_sum : '0;
            res.total   = region_total;
            pending     = {pending, res};
        endfunction

        function void check_result(logic [OP_W-1:0] op, logic [DIST_W-1:0] l1_dist,
                                   logic [CNT_W-1:0] total);
            region_result_t want;
            if (pending.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result beat: op %0d dist %0d total %0d",
                             op, l1_dist, total);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (op !== want.op || l1_dist !== want.l1_dist || total !== want.total)
            begin
                if (mismatches < 10)
                    $display({"mismatch: expected op %0d dist %0d total %0d, ",
                              "got op %0d dist %0d total %0d"},
                             want.op, want.l1_dist, want.total, op, l1_dist, total);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic             cfg_write_en;
    logic [CFG_W-1:0] cfg_write_data;

    rmm_in_if  in_bus ();
    rmm_out_if out_bus ();

    region_tracker tracker = new();

    bit calm;
    int cycle_count;
    int results_seen;
    int hold_left;
    bit hold_done;

    logic [CFG_W-1:0] phase_channels [12] = '{
        5'd16, 5'd1, 5'd7, 5'd0, 5'd31, 5'd2, 5'd16, 5'd5, 5'd20, 5'd12, 5'd3, 5'd16
    };

    region_mean_merge_l1_distance u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_ch          (in_bus),
        .out_ch         (out_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: check accepted beats, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            tracker.check_result(out_bus.completed_operation, out_bus.distance,
                                 out_bus.total_pixel_count);
            results_seen = results_seen + 1;
        end
        if (hold_left > 0)
        begin
            out_bus.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            // long hold-off so the block backs up onto its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_bus.ready <= 1'b0;
        end
        else
            out_bus.ready <= calm || ($urandom_range(0, 99) >= 19);
    end

    function automatic logic [VAL_W-1:0] rand_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return {VAL_W{1'b1}};
        return VAL_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return CNT_MAX;
        if (r < 50)
            return CNT_W'($urandom_range(0, 255));
        if (r < 60)
            return CNT_MAX - CNT_W'($urandom_range(0, 255));
        return CNT_W'($urandom());
    endfunction

    function automatic op_t rand_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return OP_LOAD;
        if (r < 65)
            return OP_QUERY;
        return OP_MERGE;
    endfunction

    task automatic send_element(op_t op, logic [VAL_W-1:0] v, logic [CNT_W-1:0] d);
        op_t use_op;
        use_op = op;
        // never read a mean that was not loaded yet
        if ((op == OP_QUERY || op == OP_MERGE) && !tracker.written[tracker.position])
            use_op = OP_LOAD;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 19)
            begin
                in_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_bus.valid              <= 1'b1;
        in_bus.operation          <= use_op;
        in_bus.feature_value      <= v;
        in_bus.region_pixel_count <= d;
        do
            @(posedge clk);
        while (!in_bus.ready);
        tracker.note_element(use_op, v, d);
    endtask

    task automatic send_vector3(op_t op, logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                logic [VAL_W-1:0] c, logic [CNT_W-1:0] d);
        send_element(op, a, d);
        send_element(op, b, d);
        send_element(op, c, d);
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_channels(logic [CFG_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        tracker.set_channels(value);
    endtask

    task automatic run_phase(int unsigned items);
        int unsigned sent;
        int unsigned kind;
        op_t         op;
        logic [CNT_W-1:0] d;
        bit          mixed;
        sent = 0;
        while (sent < items)
        begin
            kind = $urandom_range(0, 99);
            d    = rand_count();
            if (kind < 8)
            begin
                // stray beat, any op including the ignored one
                send_element(op_t'($urandom_range(0, 3)), rand_value(), d);
                sent++;
            end
            else
            begin
                mixed = (kind < 16);
                op    = rand_op();
                do
                begin
                    send_element(mixed ? rand_op() : op, rand_value(), d);
                    sent++;
                end
                while (tracker.position != 0 && sent < items);
            end
        end
    endtask

    initial
    begin
        rst_n                     = 1'b0;
        cfg_write_en              = 1'b0;
        cfg_write_data            = '0;
        in_bus.valid              = 1'b0;
        in_bus.operation          = OP_LOAD;
        in_bus.feature_value      = '0;
        in_bus.region_pixel_count = '0;
        out_bus.ready             = 1'b0;
        calm                      = 1'b0;
        cycle_count               = 0;
        results_seen              = 0;
        hold_left                 = 0;
        hold_done                 = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset channel count
        send_vector3(OP_LOAD,  16'h0000, 16'hFFFF, 16'h1234, 24'h000000);
        send_vector3(OP_QUERY, 16'hFFFF, 16'h0000, 16'h1234, CNT_MAX);
        // both counts zero keeps the old means
        send_vector3(OP_MERGE, 16'hFFFF, 16'h0000, 16'h5555, 24'h000000);
        send_element(OP_NONE, 16'hABCD, 24'h5A5A5A);
        send_vector3(OP_MERGE, 16'hFFFF, 16'hFFFF, 16'h0000, CNT_MAX);
        // count saturation
        send_vector3(OP_MERGE, 16'h0000, 16'h0000, 16'h0001, CNT_MAX);
        wait_drained();
        write_channels(5'd1);
        send_element(OP_LOAD, 16'h0001, 24'h000001);
        // tie rounds up
        send_element(OP_MERGE, 16'h0000, 24'h000001);
        wait_drained();
        write_channels(5'd0);
        send_element(OP_QUERY, 16'h0000, 24'h000000);

        foreach (phase_channels[i])
        begin
            wait_drained();
            write_channels(phase_channels[i]);
            calm = (i == 6);
            run_phase($urandom_range(55, 80));
        end
        calm = 1'b0;
        wait_drained();

        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
